/* hw/rtl/sha1_pkg.sv */
// Shared types and constants of the SHA-1 hash engine.
package sha1_pkg;

   // one queued item: message byte plus its flags
   typedef struct packed {
      logic [7:0] message_byte;
      logic       has_byte;
      logic       end_of_message;
   } item_type;

   // back-end sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_ADD,
      ST_PAD,
      ST_OUT
   } state_type;

   typedef logic [31:0] word_type;

   localparam int unsigned CHAIN_WORDS = 5;
   localparam int unsigned SCHED_WORDS = 16;
   localparam int unsigned ROUNDS      = 80;

   localparam word_type INIT_H0 = 32'h67452301;
   localparam word_type INIT_H1 = 32'hEFCDAB89;
   localparam word_type INIT_H2 = 32'h98BADCFE;
   localparam word_type INIT_H3 = 32'h10325476;
   localparam word_type INIT_H4 = 32'hC3D2E1F0;

   localparam word_type K_CH  = 32'h5A827999;
   localparam word_type K_PAR = 32'h6ED9EBA1;
   localparam word_type K_MAJ = 32'h8F1BBCDC;
   localparam word_type K_PAR2 = 32'hCA62C1D6;

   localparam logic [7:0] PAD_BYTE = 8'h80;

   // UUID version-5 stamp on digest bytes 6 and 8
   localparam word_type VER_MASK  = 32'hFFFF0FFF;
   localparam word_type VER_BITS  = 32'h00005000;
   localparam word_type VAR_MASK  = 32'h3FFFFFFF;
   localparam word_type VAR_BITS  = 32'h80000000;

   localparam logic [5:0] LAST_BYTE_POS = 6'h3f;
   localparam logic [5:0] LEN_POS       = 6'd56;

endpackage

/* hw/rtl/sha1_hash_engine_top.sv */
// Streaming SHA-1 engine: top level with the stamp register and the two halves.
//
// Usage:
//  - Request channel (req_valid / req_stall): one beat per message byte,
//    req_has_byte marks a data byte, req_end_of_message closes the message.
//    A beat with only the end flag hashes what came before it (empty message
//    if nothing). A beat with neither flag is taken and ignored.
//  - Response channel (rsp_valid / rsp_stall): five beats per message, the
//    digest words 0..4 in big-endian byte order, rsp_last_word on word 4.
//  - Config channel (csr_valid / csr_ready): writes the UUID stamp bit; write
//    only while the engine is idle.
// Operation: each byte beat is written into the current block; every 64th byte
//  starts a compression (80 rounds on the single round unit plus the chain add).
//  Closing a message pads byte by byte (into a second block when the marker
//  leaves no room for the length), compresses each padded block, then shows
//  the five words, one per cycle when not stalled.
// A small request queue keeps accepting beats while the back end compresses
//  or while the receiver stalls; req_stall rises only when it is full.
// Reset (synchronous) empties the queue, restores the initial chain value,
//  clears the length and the stamp bit.
module sha1_hash_engine_top import sha1_pkg::*; #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_message_byte,
   input  logic        req_has_byte,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_uuid_stamp
);

   item_type req_item;
   item_type q_item;
   logic     q_valid;
   logic     q_pop;
   logic     stamp_ff, stamp_in;

   assign req_item.message_byte   = req_message_byte;
   assign req_item.has_byte       = req_has_byte;
   assign req_item.end_of_message = req_end_of_message;

   // stamp configuration register
   assign csr_ready = 1'b1;
   assign stamp_in  = (csr_valid && csr_ready) ? csr_uuid_stamp : stamp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stamp_ff <= 1'b0;
      end else begin
         stamp_ff <= stamp_in;
      end
   end

   sha1_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_item    (q_item)
   );

   sha1_core u_core (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_pop           (q_pop),
      .q_item          (q_item),
      .uuid_stamp      (stamp_ff),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_last_word   (rsp_last_word)
   );

endmodule

/* hw/rtl/sha1_front.sv */
// Front end: accepts request beats, drops empty items, queues the rest.
module sha1_front import sha1_pkg::*; #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  item_type req_item,
   output logic     q_valid,
   input  logic     q_pop,
   output item_type q_item
);

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

   item_type         slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;

   // a beat with neither flag is taken and discarded
   assign req_stall = (count_ff == FULL_CNT);
   assign push      = req_valid && !req_stall &&
                      (req_item.has_byte || req_item.end_of_message);
   assign q_valid   = (count_ff != '0);
   assign pop       = q_pop && q_valid;
   assign q_item    = slot_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= req_item;
      end
   end

   always_ff @(posedge clock) begin
      if (!reset) begin
         assert (count_ff <= FULL_CNT)
            else $error("sha1_front: fill count beyond depth");
      end
   end

   as_full_no_push : assert property (@(posedge clock) disable iff (reset)
      (count_ff == FULL_CNT && !pop) |=> (count_ff == FULL_CNT))
      else $error("sha1_front: full queue lost an item");

   as_pop_only_valid : assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 && !push) |=> (count_ff == '0))
      else $error("sha1_front: empty queue popped");

   as_push_counts : assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("sha1_front: push not counted");

endmodule

/* hw/rtl/sha1_core.sv */
// Back end: block assembly, padding, 80-round compression and digest output.
module sha1_core import sha1_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   output logic        q_pop,
   input  item_type    q_item,
   input  logic        uuid_stamp,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);

   state_type   st_ff, st_in;
   word_type    chain_ff [CHAIN_WORDS];
   word_type    chain_in [CHAIN_WORDS];
   word_type    w_ff [SCHED_WORDS];
   word_type    w_in [SCHED_WORDS];
   word_type    a_ff, b_ff, c_ff, d_ff, e_ff;
   word_type    a_in, b_in, c_in, d_in, e_in;
   logic [6:0]  rnd_ff, rnd_in;
   logic [60:0] len_ff, len_in;
   logic [5:0]  pad_pos_ff, pad_pos_in;
   logic        fin_ff, fin_in;
   logic        pad_ff, pad_in;
   logic        len_here_ff, len_here_in;
   logic [2:0]  idx_ff, idx_in;

   logic        take_byte;
   logic        wr_en;
   logic [5:0]  wr_pos;
   logic [7:0]  wr_byte;
   logic [7:0]  pad_data;
   logic [63:0] bit_len;
   logic        out_done;
   word_type    f_val, k_val, t_val, w_new, raw_word;

   assign take_byte = q_valid && q_item.has_byte;
   assign bit_len   = {len_ff, 3'b000};
   assign out_done  = (st_ff == ST_OUT) && !rsp_stall && (idx_ff == 3'd4);

   // next state
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_IDLE: begin
            if (q_valid) begin
               if (q_item.has_byte && len_ff[5:0] == LAST_BYTE_POS) begin
                  st_in = ST_ROUND;
               end else if (q_item.end_of_message) begin
                  st_in = ST_PAD;
               end
            end
         end
         ST_ROUND: begin
            if (rnd_ff == 7'(ROUNDS - 1)) begin
               st_in = ST_ADD;
            end
         end
         ST_ADD: begin
            if (!fin_ff) begin
               st_in = ST_IDLE;
            end else if (pad_ff && len_here_ff) begin
               st_in = ST_OUT;
            end else begin
               st_in = ST_PAD;
            end
         end
         ST_PAD: begin
            if (pad_pos_ff == LAST_BYTE_POS) begin
               st_in = ST_ROUND;
            end
         end
         ST_OUT: begin
            if (out_done) begin
               st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   // handshake outputs
   always_comb begin
      q_pop     = 1'b0;
      rsp_valid = 1'b0;
      case (st_ff)
         ST_IDLE: q_pop     = q_valid;
         ST_OUT:  rsp_valid = 1'b1;
         default: begin
            q_pop     = 1'b0;
            rsp_valid = 1'b0;
         end
      endcase
   end

   // round function and message schedule
   always_comb begin
      if (rnd_ff < 7'd20) begin
         f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         k_val = K_CH;
      end else if (rnd_ff < 7'd40) begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = K_PAR;
      end else if (rnd_ff < 7'd60) begin
         f_val = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         k_val = K_MAJ;
      end else begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = K_PAR2;
      end
      t_val = {a_ff[26:0], a_ff[31:27]} + f_val + e_ff + k_val + w_ff[0];
      w_new = w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0];
      w_new = {w_new[30:0], w_new[31]};
   end

   // padding byte: marker, zeros, then the big-endian bit length
   always_comb begin
      if (!pad_ff) begin
         pad_data = PAD_BYTE;
      end else if (len_here_ff && pad_pos_ff >= LEN_POS) begin
         pad_data = bit_len[(7 - pad_pos_ff[2:0]) * 8 +: 8];
      end else begin
         pad_data = '0;
      end
   end

   // byte write port into the schedule window
   always_comb begin
      wr_en   = 1'b0;
      wr_pos  = pad_pos_ff;
      wr_byte = pad_data;
      if (st_ff == ST_IDLE && take_byte) begin
         wr_en   = 1'b1;
         wr_pos  = len_ff[5:0];
         wr_byte = q_item.message_byte;
      end else if (st_ff == ST_PAD) begin
         wr_en = 1'b1;
      end
   end

   // datapath next values
   always_comb begin
      chain_in    = chain_ff;
      w_in        = w_ff;
      a_in        = a_ff;
      b_in        = b_ff;
      c_in        = c_ff;
      d_in        = d_ff;
      e_in        = e_ff;
      rnd_in      = rnd_ff;
      len_in      = len_ff;
      pad_pos_in  = pad_pos_ff;
      fin_in      = fin_ff;
      pad_in      = pad_ff;
      len_here_in = len_here_ff;
      idx_in      = idx_ff;

      // schedule window: shift during rounds, otherwise byte writes
      if (st_ff == ST_ROUND) begin
         for (int i = 0; i < SCHED_WORDS - 1; i++) begin
            w_in[i] = w_ff[i + 1];
         end
         w_in[SCHED_WORDS - 1] = w_new;
      end else if (wr_en) begin
         for (int i = 0; i < SCHED_WORDS; i++) begin
            for (int j = 0; j < 4; j++) begin
               if (wr_pos[5:2] == 4'(i) && wr_pos[1:0] == 2'(j)) begin
                  w_in[i][(3 - j) * 8 +: 8] = wr_byte;
               end
            end
         end
      end

      case (st_ff)
         ST_IDLE: begin
            if (q_valid) begin
               fin_in = q_item.end_of_message;
               if (take_byte) begin
                  len_in = len_ff + 61'd1;
               end
               pad_pos_in = len_in[5:0];
            end
         end
         ST_ROUND: begin
            rnd_in = rnd_ff + 7'd1;
            e_in   = d_ff;
            d_in   = c_ff;
            c_in   = {b_ff[1:0], b_ff[31:2]};
            b_in   = a_ff;
            a_in   = t_val;
         end
         ST_ADD: begin
            chain_in[0] = chain_ff[0] + a_ff;
            chain_in[1] = chain_ff[1] + b_ff;
            chain_in[2] = chain_ff[2] + c_ff;
            chain_in[3] = chain_ff[3] + d_ff;
            chain_in[4] = chain_ff[4] + e_ff;
            if (pad_ff) begin
               // marker spilled: second block carries the length
               pad_pos_in  = '0;
               len_here_in = 1'b1;
            end else begin
               pad_pos_in = len_ff[5:0];
            end
         end
         ST_PAD: begin
            if (!pad_ff) begin
               len_here_in = (pad_pos_ff < LEN_POS);
            end
            pad_in     = 1'b1;
            pad_pos_in = pad_pos_ff + 6'd1;
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               idx_in = idx_ff + 3'd1;
            end
            if (out_done) begin
               chain_in[0] = INIT_H0;
               chain_in[1] = INIT_H1;
               chain_in[2] = INIT_H2;
               chain_in[3] = INIT_H3;
               chain_in[4] = INIT_H4;
               len_in      = '0;
               fin_in      = 1'b0;
               pad_in      = 1'b0;
               len_here_in = 1'b0;
               idx_in      = '0;
            end
         end
         default: begin
            fin_in = 1'b0;
         end
      endcase

      // working variables load from the chain as a compression starts
      if (st_in == ST_ROUND && st_ff != ST_ROUND) begin
         a_in   = chain_ff[0];
         b_in   = chain_ff[1];
         c_in   = chain_ff[2];
         d_in   = chain_ff[3];
         e_in   = chain_ff[4];
         rnd_in = '0;
      end
   end

   // control and chain registers
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff       <= ST_IDLE;
         chain_ff[0] <= INIT_H0;
         chain_ff[1] <= INIT_H1;
         chain_ff[2] <= INIT_H2;
         chain_ff[3] <= INIT_H3;
         chain_ff[4] <= INIT_H4;
         rnd_ff      <= '0;
         len_ff      <= '0;
         pad_pos_ff  <= '0;
         fin_ff      <= 1'b0;
         pad_ff      <= 1'b0;
         len_here_ff <= 1'b0;
         idx_ff      <= '0;
      end else begin
         st_ff       <= st_in;
         chain_ff    <= chain_in;
         rnd_ff      <= rnd_in;
         len_ff      <= len_in;
         pad_pos_ff  <= pad_pos_in;
         fin_ff      <= fin_in;
         pad_ff      <= pad_in;
         len_here_ff <= len_here_in;
         idx_ff      <= idx_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      w_ff <= w_in;
      a_ff <= a_in;
      b_ff <= b_in;
      c_ff <= c_in;
      d_ff <= d_in;
      e_ff <= e_in;
   end

   // digest word with optional UUID stamp
   always_comb begin
      raw_word        = chain_ff[idx_ff];
      rsp_digest_word = raw_word;
      if (uuid_stamp && idx_ff == 3'd1) begin
         rsp_digest_word = (raw_word & VER_MASK) | VER_BITS;
      end else if (uuid_stamp && idx_ff == 3'd2) begin
         rsp_digest_word = (raw_word & VAR_MASK) | VAR_BITS;
      end
   end

   assign rsp_word_index = idx_ff;
   assign rsp_last_word  = (idx_ff == 3'd4);

   as_pop_in_idle : assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (st_ff == ST_IDLE))
      else $error("sha1_core: queue popped outside idle");

   as_rounds_end : assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_ROUND && rnd_ff == 7'(ROUNDS - 1)) |=> (st_ff == ST_ADD))
      else $error("sha1_core: compression did not end after the last round");

   as_pad_to_round : assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_PAD && pad_pos_ff == LAST_BYTE_POS) |=> (st_ff == ST_ROUND))
      else $error("sha1_core: padded block not compressed");

   as_word_step : assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_OUT && !rsp_stall && idx_ff != 3'd4)
      |=> (st_ff == ST_OUT && idx_ff == $past(idx_ff) + 3'd1))
      else $error("sha1_core: digest word sequence broken");

   as_out_fresh : assert property (@(posedge clock) disable iff (reset)
      out_done |=> (len_ff == '0 && idx_ff == 3'd0))
      else $error("sha1_core: engine not reinitialised after digest");

endmodule
